[hw/rtl/utf16_to_utf8_encoder_defines.svh]
// Assertion macros shared by the encoder modules.
`ifndef UTF16_TO_UTF8_ENCODER_DEFINES_SVH
`define UTF16_TO_UTF8_ENCODER_DEFINES_SVH

// Checks that a condition holds at every clock edge outside reset.
`define U2U8_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Checks that a trigger implies a condition in the cycle after it.
`define U2U8_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

[hw/rtl/u2u8_pkg.sv]
// Shared types, constants and the UTF-8 sequence builder for the encoder.
package u2u8_pkg;

  localparam int MAX_BYTES       = 6;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [15:0] HIGH_FIRST = 16'hD800;
  localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
  localparam logic [15:0] LOW_FIRST  = 16'hDC00;
  localparam logic [15:0] LOW_LAST   = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE  = 21'h10000;
  localparam logic [20:0] LIMIT_1B   = 21'h80;
  localparam logic [20:0] LIMIT_2B   = 21'h800;
  localparam logic [20:0] LIMIT_3B   = 21'h10000;
  localparam logic [7:0]  LEAD_2B    = 8'hC0;
  localparam logic [7:0]  LEAD_3B    = 8'hE0;
  localparam logic [7:0]  LEAD_4B    = 8'hF0;
  localparam logic [7:0]  CONT_MARK  = 8'h80;

  typedef logic [2:0] byte_cnt_t;

  // One UTF-8 sequence of up to four bytes.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    byte_cnt_t       len;
  } seq_t;

  // Everything one input item sends to the output side.
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    byte_cnt_t                 count;
    logic                      text_end;
  } job_t;

  function automatic seq_t utf8_encode(input logic [20:0] v);
    seq_t s;
    s = '0;
    if (v < LIMIT_1B) begin
      s.bytes[0] = v[7:0];
      s.len      = 3'd1;
    end else if (v < LIMIT_2B) begin
      s.bytes[0] = LEAD_2B | {3'b000, v[10:6]};
      s.bytes[1] = CONT_MARK | {2'b00, v[5:0]};
      s.len      = 3'd2;
    end else if (v < LIMIT_3B) begin
      s.bytes[0] = LEAD_3B | {4'b0000, v[15:12]};
      s.bytes[1] = CONT_MARK | {2'b00, v[11:6]};
      s.bytes[2] = CONT_MARK | {2'b00, v[5:0]};
      s.len      = 3'd3;
    end else begin
      s.bytes[0] = LEAD_4B | {5'b00000, v[20:18]};
      s.bytes[1] = CONT_MARK | {2'b00, v[17:12]};
      s.bytes[2] = CONT_MARK | {2'b00, v[11:6]};
      s.bytes[3] = CONT_MARK | {2'b00, v[5:0]};
      s.len      = 3'd4;
    end
    return s;
  endfunction

endpackage

[hw/rtl/u2u8_front.sv]
// Input side: pairs surrogates and turns each code unit into a byte job.
`include "utf16_to_utf8_encoder_defines.svh"

module u2u8_front
  import u2u8_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // code_unit
  input  logic        s_tlast,   // string_end
  input  logic        q_full,
  output logic        q_push,
  output job_t        q_job
);

  logic [9:0] pending_high;
  logic [9:0] pending_high_next;
  logic       pending_valid;
  logic       pending_valid_next;
  logic       accept;
  logic       is_high;
  logic       is_low;
  logic       hold_new;
  seq_t       first_seq;
  seq_t       second_seq;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign is_high  = (s_tdata >= HIGH_FIRST) && (s_tdata <= HIGH_LAST);
  assign is_low   = (s_tdata >= LOW_FIRST) && (s_tdata <= LOW_LAST);

  // A new high surrogate is held unless it completes nothing and ends the string.
  assign hold_new = is_high && !s_tlast && !(pending_valid && is_low);

  always_comb begin
    first_seq  = '0;
    second_seq = '0;
    if (pending_valid) begin
      if (is_low) begin
        first_seq = utf8_encode(SUPP_BASE + {1'b0, pending_high, s_tdata[9:0]});
      end else begin
        first_seq = utf8_encode({5'b00000, HIGH_FIRST[15:10], pending_high});
      end
    end
    if (!(pending_valid && is_low) && !hold_new) begin
      second_seq = utf8_encode({5'b00000, s_tdata});
    end
  end

  always_comb begin
    byte_cnt_t off;
    q_job          = '0;
    q_job.count    = first_seq.len + second_seq.len;
    q_job.text_end = s_tlast;
    for (int k = 0; k < MAX_BYTES; k++) begin
      off = 3'(k) - first_seq.len;
      if (3'(k) < first_seq.len) begin
        q_job.bytes[k] = first_seq.bytes[k % 4];
      end else if (off < second_seq.len) begin
        q_job.bytes[k] = second_seq.bytes[off[1:0]];
      end
    end
  end

  assign q_push = accept && (q_job.count != '0);

  always_comb begin
    pending_high_next  = pending_high;
    pending_valid_next = pending_valid;
    if (accept) begin
      pending_valid_next = hold_new;
      pending_high_next  = hold_new ? s_tdata[9:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_high  <= '0;
      pending_valid <= 1'b0;
    end else begin
      pending_high  <= pending_high_next;
      pending_valid <= pending_valid_next;
    end
  end

  `U2U8_ASSERT_NEXT(a_hold_sets_pending, accept && hold_new, pending_valid, "high surrogate not held")
  `U2U8_ASSERT_ALWAYS(a_push_or_hold, !accept || q_push || hold_new, "accepted unit produced no job")

endmodule

[hw/rtl/u2u8_queue.sv]
// Short job queue between the input and output sides.
`include "utf16_to_utf8_encoder_defines.svh"

module u2u8_queue
  import u2u8_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic avail,
  output job_t head_job
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  job_t          slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] fill;
  logic          do_push;
  logic          do_pop;

  assign full     = (fill == FULL_CNT);
  assign avail    = (fill != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && avail;
  assign head_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  `U2U8_ASSERT_ALWAYS(a_no_push_full, !(push && full), "push into full queue")
  `U2U8_ASSERT_ALWAYS(a_no_pop_empty, !(pop && !avail), "pop from empty queue")

endmodule

[hw/rtl/u2u8_back.sv]
// Output side: sends the bytes of each job one per cycle while m_tready is high.
`include "utf16_to_utf8_encoder_defines.svh"

module u2u8_back
  import u2u8_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       q_avail,
  input  job_t       q_job,
  output logic       q_pop,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // utf8_byte
  output logic       m_tlast,   // run_last
  output logic [0:0] m_tuser    // text_done
);

  job_t      cur;
  logic      cur_valid;
  byte_cnt_t idx;
  logic      load;

  assign m_tvalid   = cur_valid;
  assign m_tdata    = cur.bytes[idx];
  assign m_tlast    = (idx == cur.count - 1'b1);
  assign m_tuser[0] = m_tlast && cur.text_end;

  // The next job loads as the last byte of the current one is taken, or whenever no job is held.
  assign load  = !cur_valid || (m_tready && m_tlast);
  assign q_pop = load && q_avail;

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= q_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      cur_valid <= q_avail;
      idx       <= '0;
    end else if (m_tready) begin
      idx <= idx + 1'b1;
    end
  end

  `U2U8_ASSERT_ALWAYS(a_idx_in_job, !cur_valid || (idx < cur.count), "byte index past job")
  `U2U8_ASSERT_ALWAYS(a_job_not_empty, !cur_valid || (cur.count != '0), "empty job loaded")

endmodule

[hw/rtl/utf16_to_utf8_encoder.sv]
// UTF-16 to UTF-8 encoder top level: input side, job queue and output side.
//
// The block takes one UTF-16 code unit per request and sends out its UTF-8 bytes, one
// byte per output request. A unit is accepted in any cycle in which the job queue
// (DEPTH entries, four by default) has room, so units may arrive back to back. Each
// unit yields zero to six bytes; the output side sends one byte per cycle while
// m_tready is high, so in steady state a unit holds the output for as long as its
// bytes take (one for ASCII, up to six when a held high surrogate is flushed before
// a 3-byte unit), and a held high surrogate costs nothing until the next unit
// arrives. When the output side is idle, an accepted unit is first written into the
// job queue and then loaded into the output side's job register before its first
// byte is presented. tlast marks the last byte of each job, and tuser marks the
// final byte of the string.
module utf16_to_utf8_encoder
  import u2u8_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // code_unit
  input  logic        s_tlast,   // string_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // utf8_byte
  output logic        m_tlast,   // run_last
  output logic [0:0]  m_tuser    // text_done
);

  logic q_full;
  logic q_push;
  job_t q_push_job;
  logic q_pop;
  logic q_avail;
  job_t q_head_job;

  u2u8_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (q_push_job)
  );

  u2u8_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_push_job),
    .full     (q_full),
    .pop      (q_pop),
    .avail    (q_avail),
    .head_job (q_head_job)
  );

  u2u8_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_avail  (q_avail),
    .q_job    (q_head_job),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule
